/* hw/rtl/ycbcr_to_palette_bayer_dither_top_macros.svh */
// Assertion macros for the converter RTL.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef YCBCR_TO_PALETTE_BAYER_DITHER_TOP_MACROS_SVH
`define YCBCR_TO_PALETTE_BAYER_DITHER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define YPTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define YPTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/yptd_pkg.sv */
// Types, constants and helper functions for the YCbCr to palette converter.
// Depends on nothing; used by every module of the block.
`default_nettype none

package yptd_pkg;

  localparam int unsigned LANES = 4;

  typedef logic signed [9:0]  delta_t;
  typedef logic signed [10:0] wsum_t;
  typedef logic [3:0]         cell_t;
  typedef logic [7:0]         pix_t;
  typedef logic [2:0]         level_t;
  typedef logic [5:0]         thresh_t;

  typedef enum logic {
    MODE_1X = 1'b0,
    MODE_2X = 1'b1
  } upscale_t;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } pipe_ctrl_t;

  localparam logic [24:0]        K_LUMA     = 25'd76309;
  localparam logic signed [26:0] K_RD       = 27'sd104597;
  localparam logic signed [26:0] K_GB       = 27'sd25674;
  localparam logic signed [26:0] K_GR       = 27'sd53278;
  localparam logic signed [26:0] K_BD       = 27'sd132201;
  localparam logic [7:0]         LUMA_OFS   = 8'd16;
  localparam logic signed [8:0]  CHROMA_OFS = 9'sd128;
  localparam logic [8:0]         LVL_STEP   = 9'd51;

  localparam cell_t CELL_TL_2X = 4'd0;
  localparam cell_t CELL_TR_2X = 4'd6;
  localparam cell_t CELL_BL_2X = 4'd13;
  localparam cell_t CELL_BR_2X = 4'd11;

  localparam logic [3:0] BAYER [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  function automatic thresh_t bayer_thresh(cell_t c);
    logic [10:0] t;
    t = (11'(BAYER[c]) * 11'd2 + 11'd1) * 11'd51;
    return thresh_t'(t >> 5);
  endfunction

  function automatic pix_t clamp_pix(wsum_t s);
    pix_t v;
    if (s < 0) begin
      v = 8'd0;
    end else if (s > 11'sd255) begin
      v = 8'd255;
    end else begin
      v = s[7:0];
    end
    return v;
  endfunction

  function automatic level_t level6(logic [8:0] s);
    level_t q;
    q = 3'd0;
    for (int k = 1; k <= 5; k++) begin
      if (s >= 9'(LVL_STEP * 9'(k))) begin
        q = q + 3'd1;
      end
    end
    return q;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/yptd_chroma.sv */
// Shared chroma unit: BT.601 color offsets from one Cb/Cr pair, registered.
// Depends on yptd_pkg.
`default_nettype none

module yptd_chroma
  import yptd_pkg::*;
(
  input  wire logic       clk,
  input  wire pipe_ctrl_t ctrl,
  input  wire logic [7:0] cb,
  input  wire logic [7:0] cr,
  output delta_t          rd_r,
  output delta_t          gd_r,
  output delta_t          bd_r
);

  logic signed [8:0]  cb_s;
  logic signed [8:0]  cr_s;
  logic signed [26:0] cb_x;
  logic signed [26:0] cr_x;
  logic signed [26:0] prod_rd;
  logic signed [26:0] prod_gd;
  logic signed [26:0] prod_bd;

  assign cb_s = $signed({1'b0, cb}) - CHROMA_OFS;
  assign cr_s = $signed({1'b0, cr}) - CHROMA_OFS;
  assign cb_x = 27'(cb_s);
  assign cr_x = 27'(cr_s);

  assign prod_rd = cr_x * K_RD;
  assign prod_gd = cb_x * K_GB + cr_x * K_GR;
  assign prod_bd = cb_x * K_BD;

  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      rd_r <= prod_rd[25:16];
      gd_r <= prod_gd[25:16];
      bd_r <= prod_bd[25:16];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/yptd_lane.sv */
// One pixel lane: luma expansion and threshold lookup, then clamp,
// dither quantization and palette index. Depends on yptd_pkg.
`default_nettype none

module yptd_lane
  import yptd_pkg::*;
(
  input  wire logic       clk,
  input  wire pipe_ctrl_t ctrl,
  input  wire pix_t       luma,
  input  wire cell_t      cell_sel,
  input  wire delta_t     rd,
  input  wire delta_t     gd,
  input  wire delta_t     bd,
  output pix_t            index_r
);

  logic [7:0]  y_off;
  logic [24:0] y_prod;
  pix_t        yy_nxt;
  pix_t        yy_r;
  thresh_t     th_r;
  wsum_t       sum_r;
  wsum_t       sum_g;
  wsum_t       sum_b;
  level_t      lvl_r;
  level_t      lvl_g;
  level_t      lvl_b;
  pix_t        index_nxt;

  assign y_off  = (luma < LUMA_OFS) ? 8'd0 : luma - LUMA_OFS;
  assign y_prod = 25'(y_off) * K_LUMA;
  assign yy_nxt = (y_prod[24:16] > 9'd255) ? 8'd255 : y_prod[23:16];

  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      yy_r <= yy_nxt;
      th_r <= bayer_thresh(cell_sel);
    end
  end

  assign sum_r = $signed({3'b000, yy_r}) + 11'(rd);
  assign sum_g = $signed({3'b000, yy_r}) - 11'(gd);
  assign sum_b = $signed({3'b000, yy_r}) + 11'(bd);

  assign lvl_r = level6(9'(clamp_pix(sum_r)) + 9'(th_r));
  assign lvl_g = level6(9'(clamp_pix(sum_g)) + 9'(th_r));
  assign lvl_b = level6(9'(clamp_pix(sum_b)) + 9'(th_r));

  assign index_nxt = 8'(lvl_r) * 8'd36 + 8'(lvl_g) * 8'd6 + 8'(lvl_b);

  always_ff @(posedge clk) begin
    if (ctrl.s2_load) begin
      index_r <= index_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ycbcr_to_palette_bayer_dither_top.sv */
// YCbCr 4:2:0 block to 6x6x6 palette indices with 4x4 ordered dither.
// One transaction carries one Cb/Cr pair, four luma samples and the
// destination dither phase; it yields the four palette indices of the 2x2
// block. Throughput is one transaction per clock unless out_stall holds the
// pipeline; there are two register stages (color offsets and luma expansion,
// then clamp, dither and quantization). Four pixel lanes share one chroma unit.
// cfg_wdata written with cfg_we selects 1x (phase-driven cells) or 2x
// (fixed cells). Depends on yptd_pkg, yptd_chroma, yptd_lane and the macros.
`default_nettype none

`include "ycbcr_to_palette_bayer_dither_top_macros.svh"

module ycbcr_to_palette_bayer_dither_top
  import yptd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_luma_top_left,
  input  wire logic [7:0] in_luma_top_right,
  input  wire logic [7:0] in_luma_bottom_left,
  input  wire logic [7:0] in_luma_bottom_right,
  input  wire logic [7:0] in_chroma_blue,
  input  wire logic [7:0] in_chroma_red,
  input  wire logic [1:0] in_dest_x_phase,
  input  wire logic [1:0] in_dest_y_phase,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_index_top_left,
  output logic [7:0]      out_index_top_right,
  output logic [7:0]      out_index_bottom_left,
  output logic [7:0]      out_index_bottom_right
);

  upscale_t   mode_r;
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       s1_ready;
  logic       s2_ready;
  pipe_ctrl_t ctrl;
  logic [1:0] x_right;
  logic [1:0] y_bottom;
  cell_t      cells [LANES];
  pix_t       lumas [LANES];
  pix_t       index [LANES];
  delta_t     rd;
  delta_t     gd;
  delta_t     bd;
  logic       index_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_1X;
    end else if (cfg_we) begin
      mode_r <= upscale_t'(cfg_wdata);
    end
  end

  assign s2_ready     = !out_valid_r || !out_stall;
  assign s1_ready     = !s1_valid_r || s2_ready;
  assign in_stall     = !s1_ready;
  assign ctrl.s1_load = in_valid && s1_ready;
  assign ctrl.s2_load = s1_valid_r && s2_ready;

  assign s1_valid_nxt  = s1_ready ? in_valid : s1_valid_r;
  assign out_valid_nxt = s2_ready ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  assign x_right  = in_dest_x_phase + 2'd1;
  assign y_bottom = in_dest_y_phase + 2'd1;

  always_comb begin
    case (mode_r)
      MODE_2X: begin
        cells[0] = CELL_TL_2X;
        cells[1] = CELL_TR_2X;
        cells[2] = CELL_BL_2X;
        cells[3] = CELL_BR_2X;
      end
      default: begin
        cells[0] = {in_dest_y_phase, in_dest_x_phase};
        cells[1] = {in_dest_y_phase, x_right};
        cells[2] = {y_bottom, in_dest_x_phase};
        cells[3] = {y_bottom, x_right};
      end
    endcase
  end

  assign lumas[0] = in_luma_top_left;
  assign lumas[1] = in_luma_top_right;
  assign lumas[2] = in_luma_bottom_left;
  assign lumas[3] = in_luma_bottom_right;

  yptd_chroma u_chroma (
    .clk  (clk),
    .ctrl (ctrl),
    .cb   (in_chroma_blue),
    .cr   (in_chroma_red),
    .rd_r (rd),
    .gd_r (gd),
    .bd_r (bd)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    yptd_lane u_lane (
      .clk      (clk),
      .ctrl     (ctrl),
      .luma     (lumas[i]),
      .cell_sel (cells[i]),
      .rd       (rd),
      .gd       (gd),
      .bd       (bd),
      .index_r  (index[i])
    );
  end

  assign out_index_top_left     = index[0];
  assign out_index_top_right    = index[1];
  assign out_index_bottom_left  = index[2];
  assign out_index_bottom_right = index[3];

  assign index_ok = (out_index_top_left <= 8'd215) && (out_index_top_right <= 8'd215) &&
                    (out_index_bottom_left <= 8'd215) && (out_index_bottom_right <= 8'd215);

  `YPTD_ASSERT_NOW(a_empty_accepts, !s1_valid_r, !in_stall, "empty stage 1 stalls input")
  `YPTD_ASSERT_NEXT(a_s1_holds, s1_valid_r && !s2_ready, s1_valid_r, "stage 1 transaction lost")
  `YPTD_ASSERT_NEXT(a_s2_fills, s1_valid_r && s2_ready, out_valid, "stage 1 did not advance")
  `YPTD_ASSERT_NOW(a_index_range, out_valid, index_ok, "palette index out of range")

endmodule

`default_nettype wire

/* bench/tb_ycbcr_to_palette_bayer_dither_top.sv */
// Testbench for ycbcr_to_palette_bayer_dither_top: directed and random 2x2 chroma blocks
// in both upscale modes, predicted palette indices checked in order on the result side.
// Depends on yptd_pkg and the block's RTL.
module tb_ycbcr_to_palette_bayer_dither_top;
  import yptd_pkg::*;

  typedef struct packed {
    logic [3:0][7:0] luma;  // [0] top left, [1] top right, [2] bottom left, [3] bottom right
    logic [7:0]      cb;
    logic [7:0]      cr;
    logic [1:0]      px;
    logic [1:0]      py;
  } chroma_block_t;

  typedef logic [3:0][7:0] indices_t;

  localparam int DITHER_RANK [16] = '{0, 8, 2, 10, 12, 4, 14, 6, 3, 11, 1, 9, 15, 7, 13, 5};
  localparam int CELL_2X [4] = '{0 * 4 + 0, 1 * 4 + 2, 3 * 4 + 1, 2 * 4 + 3};
  localparam upscale_t MODE_PLAN [4] = '{MODE_1X, MODE_2X, MODE_1X, MODE_2X};
  localparam int BLOCKS_PER_PHASE = 133;
  localparam int WATCHDOG_LIMIT = 5000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_luma_top_left = 8'd0;
  logic [7:0] in_luma_top_right = 8'd0;
  logic [7:0] in_luma_bottom_left = 8'd0;
  logic [7:0] in_luma_bottom_right = 8'd0;
  logic [7:0] in_chroma_blue = 8'd0;
  logic [7:0] in_chroma_red = 8'd0;
  logic [1:0] in_dest_x_phase = 2'd0;
  logic [1:0] in_dest_y_phase = 2'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_index_top_left;
  logic [7:0] out_index_top_right;
  logic [7:0] out_index_bottom_left;
  logic [7:0] out_index_bottom_right;

  chroma_block_t pending_blocks[$];
  indices_t      expected_indices[$];
  chroma_block_t cur_block;
  indices_t      got_indices;
  indices_t      want_indices;
  upscale_t      mode_now = MODE_1X;
  int            mismatches = 0;
  int            drv_gap = 0;
  int            stall_left = 0;
  bit            drv_quiet = 1'b0;
  bit            mon_quiet = 1'b0;
  string         index_names [4] = '{"index_top_left", "index_top_right",
                                     "index_bottom_left", "index_bottom_right"};

  ycbcr_to_palette_bayer_dither_top u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_luma_top_left      (in_luma_top_left),
    .in_luma_top_right     (in_luma_top_right),
    .in_luma_bottom_left   (in_luma_bottom_left),
    .in_luma_bottom_right  (in_luma_bottom_right),
    .in_chroma_blue        (in_chroma_blue),
    .in_chroma_red         (in_chroma_red),
    .in_dest_x_phase       (in_dest_x_phase),
    .in_dest_y_phase       (in_dest_y_phase),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_index_top_left    (out_index_top_left),
    .out_index_top_right   (out_index_top_right),
    .out_index_bottom_left (out_index_bottom_left),
    .out_index_bottom_right(out_index_bottom_right)
  );

  always #5 clk = ~clk;

  function automatic int clip8(longint v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return int'(v);
  endfunction

  function automatic int quant6(longint sum, int th);
    int q;
    q = (clip8(sum) + th) * 5 / 255;
    return (q > 5) ? 5 : q;
  endfunction

  function automatic indices_t predict_indices(chroma_block_t blk, upscale_t m);
    longint   cb, cr, rd, gd, bd, yy;
    int       row, col, cell_no, th;
    indices_t idx;
    cb = blk.cb;
    cb = cb - 128;
    cr = blk.cr;
    cr = cr - 128;
    rd = (cr * 104597) >>> 16;
    gd = (cb * 25674 + cr * 53278) >>> 16;
    bd = (cb * 132201) >>> 16;
    for (int k = 0; k < 4; k++) begin
      yy = blk.luma[k];
      yy = (yy < 16) ? 0 : clip8(((yy - 16) * 76309) >>> 16);
      if (m == MODE_2X) begin
        cell_no = CELL_2X[k];
      end else begin
        col = (int'(blk.px) + k % 2) % 4;
        row = (int'(blk.py) + k / 2) % 4;
        cell_no = row * 4 + col;
      end
      th = (DITHER_RANK[cell_no] * 2 + 1) * 51 / 32;
      idx[k] = 8'(quant6(yy + rd, th) * 36 + quant6(yy - gd, th) * 6 + quant6(yy + bd, th));
    end
    return idx;
  endfunction

  function automatic int idle_len(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] v;
    case ($urandom_range(0, 11))
      0: v = 8'd0;
      1: v = 8'd255;
      2: v = 8'd15;
      3: v = 8'd16;
      4: v = 8'd128;
      default: v = 8'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  function automatic chroma_block_t make_block(logic [7:0] ytl, logic [7:0] ytr,
                                               logic [7:0] ybl, logic [7:0] ybr,
                                               logic [7:0] cb, logic [7:0] cr,
                                               logic [1:0] px, logic [1:0] py);
    chroma_block_t blk;
    blk.luma = {ybr, ybl, ytr, ytl};
    blk.cb = cb;
    blk.cr = cr;
    blk.px = px;
    blk.py = py;
    return blk;
  endfunction

  task automatic set_mode(upscale_t m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_now = m;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_blocks.size() != 0 || in_valid || expected_indices.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_indices.push_back(predict_indices(cur_block, mode_now));
      end
      if (!in_valid || !in_stall) begin
        if ($urandom_range(0, 199) == 0) drv_quiet = !drv_quiet;
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (pending_blocks.size() > 0) begin
          cur_block = pending_blocks.pop_front();
          in_luma_top_left <= cur_block.luma[0];
          in_luma_top_right <= cur_block.luma[1];
          in_luma_bottom_left <= cur_block.luma[2];
          in_luma_bottom_right <= cur_block.luma[3];
          in_chroma_blue <= cur_block.cb;
          in_chroma_red <= cur_block.cr;
          in_dest_x_phase <= cur_block.px;
          in_dest_y_phase <= cur_block.py;
          in_valid <= 1'b1;
          drv_gap = idle_len(drv_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_indices = {out_index_bottom_right, out_index_bottom_left,
                       out_index_top_right, out_index_top_left};
        if (expected_indices.size() == 0) begin
          $error("result transaction with no block outstanding");
          mismatches++;
        end else begin
          want_indices = expected_indices.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got_indices[k] !== want_indices[k]) begin
              $error("%s: expected %0d, actual %0d", index_names[k], want_indices[k],
                     got_indices[k]);
              mismatches++;
            end
          end
        end
      end
      if ($urandom_range(0, 199) == 0) mon_quiet = !mon_quiet;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = idle_len(mon_quiet);
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((pending_blocks.size() != 0 || in_valid || expected_indices.size() != 0) &&
          !(in_valid && !in_stall) && !(out_valid && !out_stall))
        idle_cycles++;
      else
        idle_cycles = 0;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset mode is 1x
    pending_blocks.push_back(make_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0, 2'd0));
    pending_blocks.push_back(make_block(8'd255, 8'd255, 8'd255, 8'd255,
                                        8'd255, 8'd255, 2'd3, 2'd3));
    pending_blocks.push_back(make_block(8'd15, 8'd16, 8'd17, 8'd235,
                                        8'd128, 8'd128, 2'd1, 2'd2));
    pending_blocks.push_back(make_block(8'd255, 8'd255, 8'd255, 8'd255,
                                        8'd0, 8'd255, 2'd2, 2'd3));
    pending_blocks.push_back(make_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 2'd3, 2'd0));
    pending_blocks.push_back(make_block(8'd128, 8'd128, 8'd128, 8'd128,
                                        8'd128, 8'd128, 2'd0, 2'd1));
    pending_blocks.push_back(make_block(8'd200, 8'd100, 8'd50, 8'd25,
                                        8'd0, 8'd0, 2'd3, 2'd1));
    pending_blocks.push_back(make_block(8'd16, 8'd16, 8'd16, 8'd16, 8'd0, 8'd0, 2'd2, 2'd2));
    pending_blocks.push_back(make_block(8'd30, 8'd60, 8'd90, 8'd120,
                                        8'd200, 8'd60, 2'd1, 2'd3));
    pending_blocks.push_back(make_block(8'hAA, 8'h55, 8'hAA, 8'h55,
                                        8'h55, 8'hAA, 2'd2, 2'd1));
    pending_blocks.push_back(make_block(8'h55, 8'hAA, 8'h55, 8'hAA,
                                        8'hAA, 8'h55, 2'd1, 2'd0));
    pending_blocks.push_back(make_block(8'd235, 8'd240, 8'd20, 8'd5,
                                        8'd16, 8'd240, 2'd3, 2'd2));
    wait_idle();

    set_mode(MODE_2X);
    pending_blocks.push_back(make_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd3, 2'd3));
    pending_blocks.push_back(make_block(8'd255, 8'd255, 8'd255, 8'd255,
                                        8'd255, 8'd255, 2'd0, 2'd0));
    pending_blocks.push_back(make_block(8'd128, 8'd128, 8'd128, 8'd128,
                                        8'd128, 8'd128, 2'd1, 2'd2));
    pending_blocks.push_back(make_block(8'h55, 8'hAA, 8'h55, 8'hAA,
                                        8'hAA, 8'h55, 2'd2, 2'd1));
    pending_blocks.push_back(make_block(8'd240, 8'd240, 8'd240, 8'd240,
                                        8'd255, 8'd0, 2'd3, 2'd0));
    pending_blocks.push_back(make_block(8'd10, 8'd16, 8'd100, 8'd235,
                                        8'd90, 8'd240, 2'd0, 2'd3));
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      set_mode(MODE_PLAN[p]);
      repeat (BLOCKS_PER_PHASE)
        pending_blocks.push_back(make_block(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                                            rand_byte(), rand_byte(),
                                            2'($urandom_range(0, 3)),
                                            2'($urandom_range(0, 3))));
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
